// File: rtl/bbp_pkg.sv
// Shared constants, types and counter update function for the bimodal predictor.
package bbp_pkg;

	// Table geometry: index width is floor(log2(ENTRIES))
	localparam int unsigned ENTRIES   = 8192;
	localparam int unsigned IDX_W     = $clog2(ENTRIES + 1) - 1;
	localparam int unsigned TBL_DEPTH = 1 << IDX_W;

	localparam int unsigned ADDR_W = 32;
	localparam int unsigned CNT_W  = 40;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [1:0]       ctr_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// 2-bit counter states
	localparam ctr_t CTR_STRONG_NT = 2'd0;
	localparam ctr_t CTR_WEAK_NT   = 2'd1;
	localparam ctr_t CTR_WEAK_T    = 2'd2;
	localparam ctr_t CTR_STRONG_T  = 2'd3;

	localparam cnt_t CNT_MAX = '1;

	// Table write request
	typedef struct packed {
		logic en;
		idx_t idx;
		ctr_t val;
	} tbl_wr_t;

	// Table index from an instruction address: drop two low bits
	function automatic idx_t idx_of(logic [ADDR_W-1:0] addr);
		return addr[IDX_W+1:2];
	endfunction

	// Hysteresis update: a weak not-taken jumps straight to strong taken
	function automatic ctr_t next_ctr(ctr_t c, logic tk);
		ctr_t n;
		if (tk) begin
			n = (c == CTR_STRONG_NT) ? CTR_WEAK_NT : CTR_STRONG_T;
		end else begin
			n = (c == CTR_STRONG_T) ? CTR_WEAK_T : CTR_STRONG_NT;
		end
		return n;
	endfunction

endpackage

// File: rtl/bimodal_branch_predictor.sv
// Top level: bimodal branch predictor with 2-bit hysteresis counters.
// Timing: the table read and stage 1 capture register an item at the accepting
// edge; predict and update then write the output register when stage 1 advances.
// Throughput: one item per cycle while out_stall is low; the write-back of the
// same entry is forwarded to the following item.
// Reset: statistics clear at once; all 2^IDX_W table entries (8192 at the
// default size) are swept to zero with in_stall held high.
module bimodal_branch_predictor
	import bbp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [ADDR_W-1:0] branch_address,
	input  logic              taken,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              predicted_taken,
	output logic              prediction_correct,
	output logic [CNT_W-1:0]  branch_total,
	output logic [CNT_W-1:0]  miss_total
);

	logic    accept;
	logic    clearing;
	logic    busy;
	ctr_t    rd_data;
	tbl_wr_t wr;

	// Input handshake
	assign in_stall = clearing || busy;
	assign accept   = in_valid && !in_stall;

	bbp_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_idx   (idx_of(branch_address)),
		.rd_data  (rd_data),
		.wr       (wr),
		.clearing (clearing)
	);

	bbp_core u_core (
		.clk                (clk),
		.arst_n             (arst_n),
		.accept             (accept),
		.idx_in             (idx_of(branch_address)),
		.taken_in           (taken),
		.rd_data            (rd_data),
		.wr                 (wr),
		.busy               (busy),
		.out_stall          (out_stall),
		.out_valid          (out_valid),
		.predicted_taken    (predicted_taken),
		.prediction_correct (prediction_correct),
		.branch_total       (branch_total),
		.miss_total         (miss_total)
	);

endmodule

// File: rtl/bbp_table.sv
// Counter table memory with registered read and a clearing sweep after reset.
module bbp_table
	import bbp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    rd_en,
	input  idx_t    rd_idx,
	output ctr_t    rd_data,
	input  tbl_wr_t wr,
	output logic    clearing
);

	ctr_t mem [TBL_DEPTH];
	ctr_t rd_data_q;
	logic clearing_q;
	idx_t clr_idx_q;

	logic mem_we;
	idx_t mem_wa;
	ctr_t mem_wd;

	// Clearing sweep: one entry per cycle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == idx_t'(TBL_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Write port mux: sweep has priority (no items accepted meanwhile)
	always_comb begin
		mem_we = clearing_q | wr.en;
		mem_wa = clearing_q ? clr_idx_q : wr.idx;
		mem_wd = clearing_q ? CTR_STRONG_NT : wr.val;
	end

	// Storage, read-before-write
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	assign rd_data  = rd_data_q;
	assign clearing = clearing_q;

endmodule

// File: rtl/bbp_core.sv
// Predict/update stage with write-back forwarding, statistics and output register.
module bbp_core
	import bbp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    accept,
	input  idx_t    idx_in,
	input  logic    taken_in,
	input  ctr_t    rd_data,
	output tbl_wr_t wr,
	output logic    busy,
	input  logic    out_stall,
	output logic    out_valid,
	output logic    predicted_taken,
	output logic    prediction_correct,
	output cnt_t    branch_total,
	output cnt_t    miss_total
);

	logic valid_s1;
	idx_t idx_s1;
	logic taken_s1;

	logic wr_vld_q;
	idx_t wr_idx_q;
	ctr_t wr_val_q;

	cnt_t br_cnt_q;
	cnt_t miss_cnt_q;

	logic out_valid_q;
	logic pred_q;
	logic ok_q;
	cnt_t br_out_q;
	cnt_t miss_out_q;

	logic adv;
	logic fire;
	ctr_t ctr_cur;
	ctr_t ctr_nxt;
	logic pred;
	logic ok;
	cnt_t br_nxt;
	cnt_t miss_nxt;

	// Stage advances when the output register is free or being drained
	assign adv  = !out_valid_q || !out_stall;
	assign fire = valid_s1 && adv;
	assign busy = valid_s1 && !adv;

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1   <= idx_in;
			taken_s1 <= taken_in;
		end
	end

	// Forward the last write: the read may have raced it on the same edge
	always_comb begin
		ctr_cur = (wr_vld_q && wr_idx_q == idx_s1) ? wr_val_q : rd_data;
		pred    = ctr_cur[1];
		ok      = (pred == taken_s1);
		ctr_nxt = next_ctr(ctr_cur, taken_s1);
	end

	assign wr = '{en: fire, idx: idx_s1, val: ctr_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_vld_q <= 1'b0;
		end else if (fire) begin
			wr_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			wr_idx_q <= idx_s1;
			wr_val_q <= ctr_nxt;
		end
	end

	// Saturating statistics
	always_comb begin
		br_nxt   = (br_cnt_q == CNT_MAX) ? br_cnt_q : br_cnt_q + 1'b1;
		miss_nxt = (!ok && miss_cnt_q != CNT_MAX) ? miss_cnt_q + 1'b1 : miss_cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			br_cnt_q   <= '0;
			miss_cnt_q <= '0;
		end else if (fire) begin
			br_cnt_q   <= br_nxt;
			miss_cnt_q <= miss_nxt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pred_q     <= pred;
			ok_q       <= ok;
			br_out_q   <= br_nxt;
			miss_out_q <= miss_nxt;
		end
	end

	assign out_valid          = out_valid_q;
	assign predicted_taken    = pred_q;
	assign prediction_correct = ok_q;
	assign branch_total       = br_out_q;
	assign miss_total         = miss_out_q;

endmodule

// File: rtl/bbp_checker.sv
// Port-level checks for the bimodal branch predictor, bound to the top level.
module bbp_checker
	import bbp_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic [ADDR_W-1:0] branch_address,
	input logic              taken,
	input logic              out_valid,
	input logic              out_stall,
	input logic              predicted_taken,
	input logic              prediction_correct,
	input logic [CNT_W-1:0]  branch_total,
	input logic [CNT_W-1:0]  miss_total
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(branch_total)
			&& $stable(miss_total) && $stable(predicted_taken))
		else $error("stalled result changed");

	// Misses never outnumber branches
	a_miss_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> miss_total <= branch_total)
		else $error("miss count exceeds branch count");

	// Every result counts itself
	a_total_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> branch_total != '0)
		else $error("branch count zero on a result");

	// A miss is counted
	a_miss_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !prediction_correct |-> miss_total != '0)
		else $error("miss not counted");

endmodule

bind bimodal_branch_predictor bbp_checker u_bbp_checker (.*);
